/* design/jsu_pkg.sv */
// Shared types, constants and UTF-8 helper functions of the JSON string unescape unit.
`default_nettype none
package jsu_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U = 8'h75;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_NORMAL = 3'd0,
		PH_BACKSL = 3'd1,
		PH_HEX = 3'd2,
		PH_HELD = 3'd3,
		PH_HELD_BS = 3'd4,
		PH_HEX2 = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_RAW = 3'd1,
		OP_CP = 3'd2,
		OP_END = 3'd3,
		OP_ERR = 3'd4
	} slot_op_t;

	// One queued command: an optional held high surrogate, then an optional further action.
	typedef struct packed {
		logic s0_vld;
		logic [15:0] s0_cp;
		slot_op_t s1_op;
		logic [20:0] s1_val;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// {ok, value} for one ASCII hex digit.
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

	// {ok, byte} for a single-character escape letter.
	function automatic logic [8:0] esc_map(input logic [7:0] b);
		logic [8:0] r;
		case (b)
			8'h22: r = {1'b1, 8'h22};
			8'h5C: r = {1'b1, 8'h5C};
			8'h2F: r = {1'b1, 8'h2F};
			8'h62: r = {1'b1, 8'h08};
			8'h66: r = {1'b1, 8'h0C};
			8'h6E: r = {1'b1, 8'h0A};
			8'h72: r = {1'b1, 8'h0D};
			8'h74: r = {1'b1, 8'h09};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] utf8_len(input logic [20:0] cp);
		logic [2:0] r;
		if (cp < 21'h80) begin
			r = 3'd1;
		end else if (cp < 21'h800) begin
			r = 3'd2;
		end else if (cp < 21'h10000) begin
			r = 3'd3;
		end else begin
			r = 3'd4;
		end
		return r;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
		logic [2:0] len;
		logic [7:0] r;
		len = utf8_len(cp);
		r = 8'h00;
		case (len)
			3'd1: r = {1'b0, cp[6:0]};
			3'd2: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			3'd3: begin
				case (idx)
					2'd0: r = {4'b1110, cp[15:12]};
					2'd1: r = {2'b10, cp[11:6]};
					default: r = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				case (idx)
					2'd0: r = {5'b11110, cp[20:18]};
					2'd1: r = {2'b10, cp[17:12]};
					2'd2: r = {2'b10, cp[11:6]};
					default: r = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/jsu_in_if.sv */
// Input channel: one raw string byte or a text-end mark per beat.
`default_nettype none
interface jsu_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic text_end;

	modport source(output valid, output data_byte, output text_end, input ready);
	modport sink(input valid, input data_byte, input text_end, output ready);
endinterface
`default_nettype wire

/* design/jsu_out_if.sv */
// Output channel: one decoded byte or an end/error result per beat.
`default_nettype none
interface jsu_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic last;

	modport source(output valid, output out_byte, output kind, output last, input ready);
	modport sink(input valid, input out_byte, input kind, input last, output ready);
endinterface
`default_nettype wire

/* design/jsu_front.sv */
// Front end: escape and surrogate state machine that turns input beats into commands.
`default_nettype none
module jsu_front (
	input wire logic clk,
	input wire logic arst_n,
	jsu_in_if.sink din,
	input wire jsu_pkg::fifo_stat_t stat,
	output logic push,
	output jsu_pkg::cmd_t cmd
);

	jsu_pkg::phase_t phase_q, phase_d;
	logic [15:0] acc_q, acc_d;
	logic [1:0] cnt_q, cnt_d;
	logic [15:0] held_q, held_d;

	logic accept;
	logic [7:0] b;
	logic [4:0] hx;
	logic [8:0] esc;
	logic [15:0] acc_n;
	logic is_quote, is_bs, is_u;
	logic acc_high, acc_low;

	assign din.ready = !stat.full;
	assign accept = din.valid && din.ready;
	assign b = din.data_byte;
	assign hx = jsu_pkg::hex_digit(b);
	assign esc = jsu_pkg::esc_map(b);
	assign acc_n = {acc_q[11:0], hx[3:0]};
	assign is_quote = (b == jsu_pkg::CH_QUOTE);
	assign is_bs = (b == jsu_pkg::CH_BSLASH);
	assign is_u = (b == jsu_pkg::CH_U);
	assign acc_high = (acc_n[15:10] == 6'b110110);
	assign acc_low = (acc_n[15:10] == 6'b110111);

	// Next state.
	always_comb begin
		phase_d = phase_q;
		acc_d = acc_q;
		cnt_d = cnt_q;
		held_d = held_q;
		if (din.text_end) begin
			phase_d = jsu_pkg::PH_NORMAL;
			acc_d = '0;
			cnt_d = '0;
			held_d = '0;
		end else begin
			case (phase_q)
				jsu_pkg::PH_BACKSL: begin
					if (is_u) begin
						phase_d = jsu_pkg::PH_HEX;
						acc_d = '0;
						cnt_d = '0;
					end else if (esc[8]) begin
						phase_d = jsu_pkg::PH_NORMAL;
					end else begin
						phase_d = jsu_pkg::PH_NORMAL;
						acc_d = '0;
						cnt_d = '0;
						held_d = '0;
					end
				end
				jsu_pkg::PH_HEX, jsu_pkg::PH_HEX2: begin
					if (!hx[4]) begin
						phase_d = jsu_pkg::PH_NORMAL;
						acc_d = '0;
						cnt_d = '0;
						held_d = '0;
					end else if (cnt_q == 2'd3) begin
						acc_d = '0;
						cnt_d = '0;
						if (phase_q == jsu_pkg::PH_HEX2 && acc_low) begin
							held_d = '0;
							phase_d = jsu_pkg::PH_NORMAL;
						end else if (acc_high) begin
							held_d = acc_n;
							phase_d = jsu_pkg::PH_HELD;
						end else begin
							held_d = (phase_q == jsu_pkg::PH_HEX2) ? 16'h0000 : held_q;
							phase_d = jsu_pkg::PH_NORMAL;
						end
					end else begin
						acc_d = acc_n;
						cnt_d = cnt_q + 2'd1;
					end
				end
				jsu_pkg::PH_HELD: begin
					if (is_bs) begin
						phase_d = jsu_pkg::PH_HELD_BS;
					end else begin
						phase_d = jsu_pkg::PH_NORMAL;
						held_d = '0;
						if (is_quote) begin
							acc_d = '0;
							cnt_d = '0;
						end
					end
				end
				jsu_pkg::PH_HELD_BS: begin
					if (is_u) begin
						phase_d = jsu_pkg::PH_HEX2;
						acc_d = '0;
						cnt_d = '0;
					end else begin
						phase_d = jsu_pkg::PH_NORMAL;
						held_d = '0;
						if (!esc[8]) begin
							acc_d = '0;
							cnt_d = '0;
						end
					end
				end
				default: begin
					if (is_quote) begin
						phase_d = jsu_pkg::PH_NORMAL;
						acc_d = '0;
						cnt_d = '0;
						held_d = '0;
					end else if (is_bs) begin
						phase_d = jsu_pkg::PH_BACKSL;
					end else begin
						phase_d = jsu_pkg::PH_NORMAL;
					end
				end
			endcase
		end
	end

	// Command for the back end.
	always_comb begin
		cmd.s0_vld = 1'b0;
		cmd.s0_cp = held_q;
		cmd.s1_op = jsu_pkg::OP_NONE;
		cmd.s1_val = {13'd0, b};
		if (din.text_end) begin
			cmd.s0_vld = (phase_q == jsu_pkg::PH_HELD) || (phase_q == jsu_pkg::PH_HELD_BS) ||
				(phase_q == jsu_pkg::PH_HEX2);
			cmd.s1_op = jsu_pkg::OP_ERR;
		end else begin
			case (phase_q)
				jsu_pkg::PH_BACKSL: begin
					if (is_u) begin
						cmd.s1_op = jsu_pkg::OP_NONE;
					end else if (esc[8]) begin
						cmd.s1_op = jsu_pkg::OP_RAW;
						cmd.s1_val = {13'd0, esc[7:0]};
					end else begin
						cmd.s1_op = jsu_pkg::OP_ERR;
					end
				end
				jsu_pkg::PH_HEX: begin
					if (!hx[4]) begin
						cmd.s1_op = jsu_pkg::OP_ERR;
					end else if (cnt_q == 2'd3 && !acc_high) begin
						cmd.s1_op = jsu_pkg::OP_CP;
						cmd.s1_val = {5'd0, acc_n};
					end
				end
				jsu_pkg::PH_HELD: begin
					if (!is_bs) begin
						cmd.s0_vld = 1'b1;
						cmd.s1_op = is_quote ? jsu_pkg::OP_END : jsu_pkg::OP_RAW;
					end
				end
				jsu_pkg::PH_HELD_BS: begin
					if (!is_u) begin
						cmd.s0_vld = 1'b1;
						if (esc[8]) begin
							cmd.s1_op = jsu_pkg::OP_RAW;
							cmd.s1_val = {13'd0, esc[7:0]};
						end else begin
							cmd.s1_op = jsu_pkg::OP_ERR;
						end
					end
				end
				jsu_pkg::PH_HEX2: begin
					if (!hx[4]) begin
						cmd.s0_vld = 1'b1;
						cmd.s1_op = jsu_pkg::OP_ERR;
					end else if (cnt_q == 2'd3) begin
						if (acc_low) begin
							cmd.s1_op = jsu_pkg::OP_CP;
							cmd.s1_val = 21'h10000 + {1'b0, held_q[9:0], acc_n[9:0]};
						end else begin
							cmd.s0_vld = 1'b1;
							if (!acc_high) begin
								cmd.s1_op = jsu_pkg::OP_CP;
								cmd.s1_val = {5'd0, acc_n};
							end
						end
					end
				end
				default: begin
					if (is_quote) begin
						cmd.s1_op = jsu_pkg::OP_END;
					end else if (!is_bs) begin
						cmd.s1_op = jsu_pkg::OP_RAW;
					end
				end
			endcase
		end
	end

	assign push = accept && (cmd.s0_vld || (cmd.s1_op != jsu_pkg::OP_NONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jsu_pkg::PH_NORMAL;
			acc_q <= '0;
			cnt_q <= '0;
			held_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_q <= acc_d;
			cnt_q <= cnt_d;
			held_q <= held_d;
		end
	end

endmodule
`default_nettype wire

/* design/jsu_cmd_fifo.sv */
// Short command queue between the front and back ends.
`default_nettype none
module jsu_cmd_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire jsu_pkg::cmd_t wr_cmd,
	input wire logic pop,
	output jsu_pkg::cmd_t head,
	output jsu_pkg::fifo_stat_t stat
);

	jsu_pkg::cmd_t mem_q [jsu_pkg::FIFO_DEPTH];
	logic [jsu_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [jsu_pkg::CNT_W-1:0] cnt_q;

	assign stat.full = (cnt_q == jsu_pkg::CNT_W'(jsu_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + jsu_pkg::PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + jsu_pkg::PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + jsu_pkg::CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - jsu_pkg::CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full || pop))
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("command popped from an empty queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + jsu_pkg::CNT_W'(1)))
		else $error("queue count did not advance on push");

endmodule
`default_nettype wire

/* design/jsu_back.sv */
// Back end: serializes queued commands into UTF-8 result beats through an output register.
`default_nettype none
module jsu_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire jsu_pkg::cmd_t head,
	input wire jsu_pkg::fifo_stat_t stat,
	output logic pop,
	jsu_out_if.source dout
);

	logic [2:0] pos_q;
	logic vld_q;
	logic [7:0] byte_q;
	jsu_pkg::kind_t kind_q;
	logic last_q;

	logic [2:0] len0, len1, total, rel;
	logic [7:0] byte_c;
	jsu_pkg::kind_t kind_c;
	logic last_c;
	logic load;

	assign len0 = head.s0_vld ? jsu_pkg::utf8_len({5'd0, head.s0_cp}) : 3'd0;

	always_comb begin
		case (head.s1_op)
			jsu_pkg::OP_CP: len1 = jsu_pkg::utf8_len(head.s1_val);
			jsu_pkg::OP_NONE: len1 = 3'd0;
			default: len1 = 3'd1;
		endcase
	end

	assign total = len0 + len1;
	assign rel = pos_q - len0;
	assign last_c = (pos_q == total - 3'd1);

	always_comb begin
		byte_c = 8'h00;
		kind_c = jsu_pkg::KIND_DATA;
		if (pos_q < len0) begin
			byte_c = jsu_pkg::utf8_byte({5'd0, head.s0_cp}, pos_q[1:0]);
		end else begin
			case (head.s1_op)
				jsu_pkg::OP_RAW: byte_c = head.s1_val[7:0];
				jsu_pkg::OP_CP: byte_c = jsu_pkg::utf8_byte(head.s1_val, rel[1:0]);
				jsu_pkg::OP_END: kind_c = jsu_pkg::KIND_END;
				jsu_pkg::OP_ERR: kind_c = jsu_pkg::KIND_ERR;
				default: byte_c = 8'h00;
			endcase
		end
	end

	assign load = !vld_q || dout.ready;
	assign pop = load && !stat.empty && last_c;

	always_ff @(posedge clk) begin
		if (load && !stat.empty) begin
			byte_q <= byte_c;
			kind_q <= kind_c;
			last_q <= last_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			pos_q <= '0;
		end else if (load) begin
			vld_q <= !stat.empty;
			if (!stat.empty) begin
				pos_q <= last_c ? 3'd0 : pos_q + 3'd1;
			end
		end
	end

	assign dout.valid = vld_q;
	assign dout.out_byte = byte_q;
	assign dout.kind = kind_q;
	assign dout.last = last_q;

endmodule
`default_nettype wire

/* design/json_string_unescape_utf8_unit.sv */
// Top level of the JSON string unescape unit: front end, command queue and UTF-8 back end.
// Usage:
//   din carries one beat per raw byte of a JSON string body, taken after the opening
//   quote; text_end set on a beat marks that the text ran out and ignores data_byte.
//   dout carries the results: decoded UTF-8 bytes (kind data), then one end beat at
//   the closing quote or one error beat on a bad escape, a bad hex digit or text end.
//   last marks the final result beat that an input beat causes; an input beat may
//   cause none (a backslash, a hex digit) or up to six results.
// Path: with an idle back end, a taken beat's command is written into the queue at the
//   accepting edge, and the back end then loads its first result into the output
//   register that drives dout.
// Throughput: one input beat per cycle while each beat yields at most one result and
//   dout is ready; the back end emits one result beat per cycle while dout is ready,
//   so a beat that expands to several UTF-8 bytes holds the back end until all are
//   out. The four-entry command queue absorbs bursts; din.ready drops only when full.
// Stall: when dout.ready is low the output register holds its beat, the back end
//   stops popping, and the front end keeps taking beats until the queue fills.
// Reset: arst_n clears the decoder to the plain-copy phase, empties the queue and
//   drops dout.valid; after an end or error result the decoder is ready for a new string.
`default_nettype none
module json_string_unescape_utf8_unit (
	input wire logic clk,
	input wire logic arst_n,
	jsu_in_if.sink din,
	jsu_out_if.source dout
);

	// Command from the front end, head of the queue, and the handshakes around it.
	jsu_pkg::cmd_t cmd;
	jsu_pkg::cmd_t head;
	jsu_pkg::fifo_stat_t stat;
	logic push;
	logic pop;

	// Classify each beat and advance the escape / surrogate state.
	jsu_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.din(din),
		.stat(stat),
		.push(push),
		.cmd(cmd)
	);

	// Hold commands so the decoder runs ahead of a stalled receiver.
	jsu_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_cmd(cmd),
		.pop(pop),
		.head(head),
		.stat(stat)
	);

	// Expand each command into result beats, one per cycle while dout is ready.
	jsu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.stat(stat),
		.pop(pop),
		.dout(dout)
	);

endmodule
`default_nettype wire

/* bench/utf8_unescape_checker.sv */
// Checker for the JSON string unescape unit: decodes the input beats and scores the results.
`timescale 1ns / 100ps
module utf8_unescape_checker (
	input logic clk,
	input logic arst_n,
	jsu_in_if din,
	jsu_out_if dout,
	output int unsigned fail_count,
	output int unsigned outstanding
);

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST = 16'hDC00;
	localparam logic [15:0] LOW_LAST = 16'hDFFF;
	localparam logic [20:0] PLANE1_BASE = 21'h10000;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;

	typedef struct {
		logic [7:0] out_byte;
		jsu_pkg::kind_t kind;
		logic last;
	} result_t;

	// decoder state, mirrored from the block
	jsu_pkg::phase_t scan_phase;
	logic [15:0] hex_accum;
	logic [1:0] digit_count;
	logic [15:0] held_high;

	result_t item_results[$];
	result_t expected_results[$];

	function void clear_decoder();
		scan_phase = jsu_pkg::PH_NORMAL;
		hex_accum = '0;
		digit_count = '0;
		held_high = '0;
	endfunction

	function void emit(input logic [7:0] b, input jsu_pkg::kind_t k);
		result_t r;
		r.out_byte = b;
		r.kind = k;
		r.last = 1'b0;
		item_results.insert(item_results.size(), r);
	endfunction

	function void emit_utf8(input logic [20:0] cp);
		if (cp < 21'h80) begin
			emit(cp[7:0], jsu_pkg::KIND_DATA);
		end else if (cp < 21'h800) begin
			emit({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA);
			emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA);
		end else if (cp < PLANE1_BASE) begin
			emit({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA);
			emit({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA);
			emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA);
		end else begin
			emit({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA);
			emit({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA);
			emit({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA);
			emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA);
		end
	endfunction

	function void close_string(input jsu_pkg::kind_t k);
		emit(8'h00, k);
		clear_decoder();
	endfunction

	function int hex_nibble(input logic [7:0] b);
		int v;
		v = -1;
		if (b >= "0" && b <= "9") v = b - "0";
		else if (b >= "a" && b <= "f") v = b - "a" + 10;
		else if (b >= "A" && b <= "F") v = b - "A" + 10;
		return v;
	endfunction

	function void take_plain(input logic [7:0] b);
		if (b == jsu_pkg::CH_QUOTE) begin
			close_string(jsu_pkg::KIND_END);
		end else if (b == jsu_pkg::CH_BSLASH) begin
			scan_phase = jsu_pkg::PH_BACKSL;
		end else begin
			emit(b, jsu_pkg::KIND_DATA);
			scan_phase = jsu_pkg::PH_NORMAL;
		end
	endfunction

	function void take_escape_letter(input logic [7:0] b);
		logic [7:0] v;
		v = 8'h00;
		case (b)
			jsu_pkg::CH_QUOTE: v = jsu_pkg::CH_QUOTE;
			jsu_pkg::CH_BSLASH: v = jsu_pkg::CH_BSLASH;
			CH_SLASH: v = CH_SLASH;
			CH_B: v = 8'h08;
			CH_F: v = 8'h0C;
			CH_N: v = 8'h0A;
			CH_R: v = 8'h0D;
			CH_T: v = 8'h09;
			jsu_pkg::CH_U: begin
				scan_phase = jsu_pkg::PH_HEX;
				hex_accum = '0;
				digit_count = '0;
				return;
			end
			default: begin
				close_string(jsu_pkg::KIND_ERR);
				return;
			end
		endcase
		emit(v, jsu_pkg::KIND_DATA);
		scan_phase = jsu_pkg::PH_NORMAL;
	endfunction

	// a finished \u code: hold a high surrogate, encode anything else
	function void take_code(input logic [15:0] cp);
		hex_accum = '0;
		digit_count = '0;
		if (cp >= HIGH_FIRST && cp <= HIGH_LAST) begin
			held_high = cp;
			scan_phase = jsu_pkg::PH_HELD;
		end else begin
			emit_utf8({5'd0, cp});
			scan_phase = jsu_pkg::PH_NORMAL;
		end
	endfunction

	function void flush_held();
		emit_utf8({5'd0, held_high});
		held_high = '0;
	endfunction

	function void decode_beat(input logic [7:0] b, input logic text_end);
		int nib;
		logic [20:0] joined;
		item_results.delete();
		if (text_end) begin
			if (scan_phase inside {jsu_pkg::PH_HELD, jsu_pkg::PH_HELD_BS, jsu_pkg::PH_HEX2})
				emit_utf8({5'd0, held_high});
			close_string(jsu_pkg::KIND_ERR);
		end else begin
			case (scan_phase)
				jsu_pkg::PH_BACKSL: take_escape_letter(b);
				jsu_pkg::PH_HEX: begin
					nib = hex_nibble(b);
					if (nib < 0) begin
						close_string(jsu_pkg::KIND_ERR);
					end else begin
						hex_accum = {hex_accum[11:0], nib[3:0]};
						if (digit_count == 2'd3) take_code(hex_accum);
						else digit_count = digit_count + 2'd1;
					end
				end
				jsu_pkg::PH_HELD: begin
					if (b == jsu_pkg::CH_BSLASH) begin
						scan_phase = jsu_pkg::PH_HELD_BS;
					end else begin
						flush_held();
						scan_phase = jsu_pkg::PH_NORMAL;
						take_plain(b);
					end
				end
				jsu_pkg::PH_HELD_BS: begin
					if (b == jsu_pkg::CH_U) begin
						scan_phase = jsu_pkg::PH_HEX2;
						hex_accum = '0;
						digit_count = '0;
					end else begin
						flush_held();
						scan_phase = jsu_pkg::PH_BACKSL;
						take_escape_letter(b);
					end
				end
				jsu_pkg::PH_HEX2: begin
					nib = hex_nibble(b);
					if (nib < 0) begin
						flush_held();
						close_string(jsu_pkg::KIND_ERR);
					end else begin
						hex_accum = {hex_accum[11:0], nib[3:0]};
						if (digit_count != 2'd3) begin
							digit_count = digit_count + 2'd1;
						end else if (hex_accum >= LOW_FIRST && hex_accum <= LOW_LAST) begin
							joined = PLANE1_BASE + 21'({(held_high - HIGH_FIRST), 10'd0})
								+ 21'(hex_accum - LOW_FIRST);
							emit_utf8(joined);
							clear_decoder();
						end else begin
							flush_held();
							take_code(hex_accum);
						end
					end
				end
				default: take_plain(b);
			endcase
		end
		if (item_results.size() != 0) item_results[$].last = 1'b1;
		foreach (item_results[i])
			expected_results.insert(expected_results.size(), item_results[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_decoder();
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (din.valid && din.ready) decode_beat(din.data_byte, din.text_end);
			if (dout.valid && dout.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result beat: out_byte %h kind %0d last %b",
						dout.out_byte, dout.kind, dout.last);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (dout.out_byte !== want.out_byte) begin
						$error("out_byte mismatch: expected %h, actual %h",
							want.out_byte, dout.out_byte);
						fail_count++;
					end
					if (dout.kind !== want.kind) begin
						$error("kind mismatch: expected %0d, actual %0d", want.kind, dout.kind);
						fail_count++;
					end
					if (dout.last !== want.last) begin
						$error("last mismatch: expected %b, actual %b", want.last, dout.last);
						fail_count++;
					end
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

/* bench/json_string_unescape_utf8_unit_tb.sv */
// Testbench top for the JSON string unescape unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module json_string_unescape_utf8_unit_tb;

	localparam int unsigned RANDOM_ITEMS = 470;
	localparam int unsigned DRAIN_CYCLES = 20;
	// the worst case, even with a long sink stall on every result, stays far below this
	localparam int unsigned CYCLE_LIMIT = 400000;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST = 16'hDC00;
	localparam logic [15:0] LOW_LAST = 16'hDFFF;

	// the single-character escape letters: " \ / b f n r t
	localparam logic [7:0] ESCAPE_LETTERS [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E,
		8'h72, 8'h74};
	// code points at the edges of the UTF-8 length classes
	localparam logic [15:0] EDGE_CODES [6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
		16'h0800, 16'hFFFF};

	typedef struct packed {
		logic [7:0] data_byte;
		logic text_end;
	} beat_t;

	logic clk;
	logic arst_n;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned cycle_count;

	beat_t string_beats[$];

	jsu_in_if din_bus();
	jsu_out_if dout_bus();

	json_string_unescape_utf8_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_bus),
		.dout(dout_bus)
	);

	utf8_unescape_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_bus),
		.dout(dout_bus),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Idle length for either side: mostly none or short, now and then a long gap.
	// A quiet stretch gives back-to-back traffic.
	function automatic int unsigned idle_len(input bit quiet);
		int unsigned r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// ---- stimulus construction ------------------------------------------------

	function void append_beat(input logic [7:0] b, input logic text_end);
		beat_t beat;
		beat.data_byte = b;
		beat.text_end = text_end;
		string_beats.insert(string_beats.size(), beat);
	endfunction

	function void push_byte(input logic [7:0] b);
		append_beat(b, 1'b0);
	endfunction

	// data_byte is don't-care on a text-end beat; randomize it anyway
	function void push_text_end();
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		append_beat(junk, 1'b1);
	endfunction

	// any byte that is copied straight through (not a quote, not a backslash)
	function logic [7:0] raw_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH) b = b ^ 8'h01;
		return b;
	endfunction

	// hex digit with a random letter case
	function logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'("0") + 8'(v);
		if ($urandom_range(0, 1) != 0) return 8'("a") + 8'(v) - 8'd10;
		return 8'("A") + 8'(v) - 8'd10;
	endfunction

	function logic [7:0] non_hex_byte();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
		return b;
	endfunction

	function logic [7:0] bad_letter();
		logic [7:0] b;
		bit known;
		do begin
			b = 8'($urandom_range(0, 255));
			known = (b == jsu_pkg::CH_U);
			foreach (ESCAPE_LETTERS[i]) if (b == ESCAPE_LETTERS[i]) known = 1'b1;
		end while (known);
		return b;
	endfunction

	// backslash, u, then the top ndigits hex digits of cp
	function void push_u(input logic [15:0] cp, input int ndigits = 4);
		push_byte(jsu_pkg::CH_BSLASH);
		push_byte(jsu_pkg::CH_U);
		for (int i = 3; i > 3 - ndigits; i--) push_byte(hex_char(cp[i*4 +: 4]));
	endfunction

	function void push_simple_escape();
		push_byte(jsu_pkg::CH_BSLASH);
		push_byte(ESCAPE_LETTERS[$urandom_range(0, 7)]);
	endfunction

	function logic [15:0] rand_high();
		return 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
	endfunction

	function logic [15:0] rand_low();
		return 16'($urandom_range(LOW_FIRST, LOW_LAST));
	endfunction

	// spread codes over the one-, two- and three-byte UTF-8 lengths and both surrogate ranges
	function logic [15:0] pick_code();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(16'h0000, 16'h007F));
			1: return 16'($urandom_range(16'h0080, 16'h07FF));
			2: begin
				if ($urandom_range(0, 1) != 0) return 16'($urandom_range(16'h0800, HIGH_FIRST - 1));
				return 16'($urandom_range(LOW_LAST + 1, 16'hFFFF));
			end
			3: return rand_high();
			4: return rand_low();
			default: return EDGE_CODES[$urandom_range(0, 5)];
		endcase
	endfunction

	function logic [15:0] pick_non_low();
		logic [15:0] cp;
		do cp = pick_code(); while (cp >= LOW_FIRST && cp <= LOW_LAST);
		return cp;
	endfunction

	// One random token. Most are well-formed pieces of a string body with random
	// content; a smaller share breaks an escape or cuts the text short.
	function void add_random_token();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 28) begin
			repeat ($urandom_range(1, 4)) push_byte(raw_byte());
		end else if (r < 40) begin
			push_simple_escape();
		end else if (r < 58) begin
			push_u(pick_code());
		end else if (r < 70) begin
			// proper surrogate pair
			push_u(rand_high());
			push_u(rand_low());
		end else if (r < 76) begin
			// high surrogate left unpaired by a plain byte, a quote or a short escape
			push_u(rand_high());
			case ($urandom_range(0, 2))
				0: push_byte(raw_byte());
				1: push_byte(jsu_pkg::CH_QUOTE);
				default: push_simple_escape();
			endcase
		end else if (r < 81) begin
			// second \u escape that is not a low surrogate; may be a new high
			push_u(rand_high());
			push_u(pick_non_low());
		end else if (r < 87) begin
			push_byte(jsu_pkg::CH_QUOTE);
		end else if (r < 91) begin
			if ($urandom_range(0, 2) == 0) push_u(rand_high());
			push_byte(jsu_pkg::CH_BSLASH);
			push_byte(bad_letter());
		end else if (r < 96) begin
			// bad hex digit, in a first or a second escape
			if ($urandom_range(0, 1) != 0) push_u(rand_high());
			push_u(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
			push_byte(non_hex_byte());
		end else begin
			// text runs out, possibly in the middle of an escape
			case ($urandom_range(0, 4))
				0: ;
				1: push_byte(jsu_pkg::CH_BSLASH);
				2: push_u(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
				3: push_u(rand_high());
				default: begin
					push_u(rand_high());
					if ($urandom_range(0, 1) != 0) push_byte(jsu_pkg::CH_BSLASH);
					else push_u(rand_low(), $urandom_range(0, 3));
				end
			endcase
			push_text_end();
		end
	endfunction

	function void build_stimulus();
		int unsigned directed_count;
		// directed: byte extremes, a short escape, a surrogate pair, a bad letter,
		// a closing quote, a text end, and a high surrogate cut off by a quote
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(jsu_pkg::CH_BSLASH);
		push_byte(jsu_pkg::CH_QUOTE);
		push_u(16'hD83D);
		push_u(16'hDE00);
		push_byte(jsu_pkg::CH_BSLASH);
		push_byte("x");
		push_byte(jsu_pkg::CH_QUOTE);
		push_text_end();
		push_u(16'hDBFF);
		push_byte(jsu_pkg::CH_QUOTE);
		directed_count = string_beats.size();
		while (string_beats.size() - directed_count < RANDOM_ITEMS) add_random_token();
	endfunction

	// ---- drivers --------------------------------------------------------------

	// Present one beat from a falling edge and hold it until a rising edge takes it.
	// Valid stays high between back-to-back beats; only the payload changes.
	task automatic send_beat(input beat_t beat, input bit quiet);
		int unsigned gap;
		gap = idle_len(quiet);
		if (gap != 0) begin
			din_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		din_bus.valid <= 1'b1;
		din_bus.data_byte <= beat.data_byte;
		din_bus.text_end <= beat.text_end;
		do @(posedge clk); while (!din_bus.ready);
		@(negedge clk);
	endtask

	// Result side: runs of ready, broken by stalls of random length.
	initial begin
		int unsigned stall;
		int unsigned rounds;
		bit quiet;
		dout_bus.ready = 1'b0;
		quiet = 1'b0;
		rounds = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rounds % 30 == 0) quiet = ($urandom_range(0, 3) == 0);
			rounds++;
			dout_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			stall = idle_len(quiet);
			if (stall != 0) begin
				dout_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	// Main sequence: reset, stream every beat, drain, verdict.
	initial begin
		bit quiet;
		arst_n = 1'b0;
		din_bus.valid = 1'b0;
		din_bus.data_byte = 8'h00;
		din_bus.text_end = 1'b0;
		quiet = 1'b0;
		build_stimulus();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (string_beats[i]) begin
			// switch between gappy and back-to-back stretches now and then
			if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
			send_beat(string_beats[i], quiet);
		end
		din_bus.valid <= 1'b0;

		// wait for every predicted result, then a little longer for strays
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
